// ===== hw/rtl/rnh_pkg.sv =====
// Shared types, codes and datapath widths for the ray nearest-hit block.
package rnh_pkg;

  localparam logic [1:0] OP_ADD_CIRCLE  = 2'd0;
  localparam logic [1:0] OP_ADD_SEGMENT = 2'd1;
  localparam logic [1:0] OP_CAST_RAY    = 2'd2;

  localparam logic KIND_CIRCLE  = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  // Signed operand width of the multiply unit, split into two unsigned limbs.
  localparam int OPW    = 68;
  localparam int LIMB_W = 34;
  localparam int ACC_W  = 2 * OPW + 2;
  // Discriminant width fed to the root unit, and the root width.
  localparam int SQ_W   = 132;
  localparam int ROOT_W = SQ_W / 2;
  // Divisor width (a or |den|), also the integer part of a dividend.
  localparam int DEN_W  = 66;

  typedef logic signed [OPW-1:0] sop_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] shape_x1;
    logic signed [31:0] shape_y1;
    logic signed [31:0] shape_x2;
    logic signed [31:0] shape_y2;
    logic [30:0]        circle_radius;
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
    logic        scene_overflow;
  } rsp_t;

  // Queued command. Loads carry {y1,x1} and {y2,x2} or the radius;
  // casts carry {oy,ox} and {dy,dx}.
  typedef struct packed {
    logic        is_cast;
    logic        kind;
    logic        ovf;
    logic [63:0] word_a;
    logic [63:0] word_b;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE, B_READ, B_PREP, B_TLOAD, B_TMUL, B_CHECK, B_DISC,
    B_SQGO, B_SQRT, B_DIVGO, B_DIV, B_NEXT, B_OUT
  } back_state_t;

  typedef enum logic [1:0] {I_IDLE, I_SQRT, I_SAT, I_DIV} iter_state_t;

  typedef enum logic {MODE_SQRT, MODE_DIV} iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
    logic [31:0]       quot;
  } iter_sts_t;

endpackage

// ===== hw/rtl/rnh_front.sv =====
// Front end: takes requests, tracks the scene fill and overflow, queues commands.
module rnh_front #(
  parameter int MAX_SHAPES = 64,
  parameter int CNTW       = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rnh_pkg::req_t req,
  input  logic          q_full,
  output logic          push,
  output logic [CNTW-1:0] push_slot,
  output rnh_pkg::cmd_t push_cmd
);
  import rnh_pkg::*;

  logic [CNTW-1:0] count;
  logic            ovf;
  logic            accept;
  logic            is_load;
  logic            is_cast;
  logic            full;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign is_load   = (req.opcode == OP_ADD_CIRCLE) || (req.opcode == OP_ADD_SEGMENT);
  assign is_cast   = (req.opcode == OP_CAST_RAY);
  assign full      = (count == CNTW'(MAX_SHAPES));

  // A load that finds the table full is taken but never reaches the queue.
  assign push      = accept && (is_cast || (is_load && !full));
  assign push_slot = count;

  always_comb begin
    push_cmd.is_cast = is_cast;
    push_cmd.kind    = (req.opcode == OP_ADD_SEGMENT) ? KIND_SEGMENT : KIND_CIRCLE;
    push_cmd.ovf     = ovf;
    if (is_cast) begin
      push_cmd.word_a = {req.ray_origin_y, req.ray_origin_x};
      push_cmd.word_b = {req.ray_dir_y, req.ray_dir_x};
    end else begin
      push_cmd.word_a = {req.shape_y1, req.shape_x1};
      if (req.opcode == OP_ADD_SEGMENT) begin
        push_cmd.word_b = {req.shape_y2, req.shape_x2};
      end else begin
        push_cmd.word_b = {33'd0, req.circle_radius};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept && is_load) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CNTW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/rnh_queue.sv =====
// Two-entry command queue between the front end and the back end.
module rnh_queue #(
  parameter int W = 200
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import rnh_pkg::*;

  logic [W-1:0] slots [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/rnh_iter.sv =====
// Iterative unit: bitwise integer square root or saturating 32-bit quotient.
module rnh_iter #(
  parameter int NUM_W = 82
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rnh_pkg::iter_ctl_t        ctl,
  input  logic [rnh_pkg::SQ_W-1:0]  sq_val,
  input  logic [NUM_W-1:0]          num,
  input  logic [rnh_pkg::DEN_W-1:0] den,
  output rnh_pkg::iter_sts_t        sts
);
  import rnh_pkg::*;

  localparam int DIVW = ((NUM_W > DEN_W + 32) ? NUM_W : DEN_W + 32) + 1;

  iter_state_t       istate;
  iter_state_t       istate_next;
  logic [6:0]        cnt;
  logic [SQ_W-1:0]   vin;
  logic [ROOT_W+1:0] srem;
  logic [ROOT_W-1:0] root;
  logic [DIVW-1:0]   drem;
  logic [DIVW-1:0]   dsh;
  logic [31:0]       quot;
  logic              done;

  logic [ROOT_W+3:0] rem2;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] sq_diff;
  logic              sq_ge;
  logic              div_ge;
  logic [DIVW-1:0]   ddiff;

  assign rem2    = {srem, vin[SQ_W-1:SQ_W-2]};
  assign trial   = {2'b00, root, 2'b01};
  assign sq_ge   = (rem2 >= trial);
  assign sq_diff = rem2 - trial;
  assign div_ge  = (drem >= dsh);
  assign ddiff   = drem - dsh;

  assign sts.done = done;
  assign sts.root = root;
  assign sts.quot = quot;

  always_comb begin
    istate_next = istate;
    unique case (istate)
      I_IDLE: begin
        if (ctl.start) begin
          istate_next = (ctl.mode == MODE_SQRT) ? I_SQRT : I_SAT;
        end
      end
      I_SQRT: begin
        if (cnt == 7'd0) begin
          istate_next = I_IDLE;
        end
      end
      I_SAT: begin
        istate_next = div_ge ? I_IDLE : I_DIV;
      end
      I_DIV: begin
        if (cnt == 7'd0) begin
          istate_next = I_IDLE;
        end
      end
      default: istate_next = I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      istate <= I_IDLE;
      done   <= 1'b0;
    end else begin
      istate <= istate_next;
      done   <= ((istate == I_SQRT) && (cnt == 7'd0)) ||
                ((istate == I_SAT) && div_ge) ||
                ((istate == I_DIV) && (cnt == 7'd0));
    end
  end

  always_ff @(posedge clk) begin
    case (istate)
      I_IDLE: begin
        if (ctl.start) begin
          vin  <= sq_val;
          srem <= '0;
          root <= '0;
          cnt  <= 7'(ROOT_W - 1);
          drem <= DIVW'(num);
          dsh  <= DIVW'(den) << 32;
          quot <= '0;
        end
      end
      I_SQRT: begin
        vin <= vin << 2;
        if (sq_ge) begin
          srem <= sq_diff[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          srem <= rem2[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
      end
      I_SAT: begin
        // A dividend of at least den * 2^32 saturates the quotient.
        if (div_ge) begin
          quot <= '1;
        end else begin
          dsh <= dsh >> 1;
          cnt <= 7'd31;
        end
      end
      I_DIV: begin
        if (div_ge) begin
          drem <= ddiff;
        end
        quot <= {quot[30:0], div_ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 7'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rnh_back.sv =====
// Back end: scene memory, shape walk with limb multiplier, nearest-hit select.
module rnh_back #(
  parameter int MAX_SHAPES = 64,
  parameter int FRAC_BITS  = 16,
  parameter int CNTW       = 7,
  parameter int IDXW       = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  logic [CNTW-1:0] q_slot,
  input  rnh_pkg::cmd_t   q_cmd,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output rnh_pkg::rsp_t   rsp
);
  import rnh_pkg::*;

  localparam int NUM_W = DEN_W + FRAC_BITS;

  logic [128:0] scene_mem [MAX_SHAPES];
  logic [128:0] rd_word;

  back_state_t state;
  back_state_t state_next;

  logic signed [31:0] ox, oy, dx, dy;
  logic [CNTW-1:0]    n_shapes;
  logic [CNTW-1:0]    idx;
  logic [CNTW-1:0]    idx_inc;
  logic               ovf_snap;
  logic               found;
  logic [31:0]        best;

  logic               kind_cur;
  logic signed [32:0] ux, uy, v2x, v2y;
  logic [30:0]        rad;

  logic [3:0]           term;
  logic [2:0]           mcnt;
  logic [OPW-1:0]       magx, magy;
  logic                 tneg;
  logic [2*LIMB_W-1:0]  pp;
  logic [1:0]           pp_sh;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     pp_wide;
  logic [ACC_W-1:0]     pp_ext;
  logic [ACC_W-1:0]     acc_sum;
  logic [LIMB_W-1:0]    la, lb;
  sop_t                 ra, rb, rc;

  sop_t opx, opy;
  logic tsub, tend, to_check, to_disc;

  sop_t             sden, sn1, sn2, nb;
  logic             seg_hit, circ_ok;
  logic [DEN_W-1:0] cnum;

  logic [SQ_W-1:0]  sq_val;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  iter_ctl_t        ictl;
  iter_sts_t        ists;

  logic out_free;
  logic mem_we;

  rnh_iter #(.NUM_W(NUM_W)) u_iter (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ictl),
    .sq_val (sq_val),
    .num    (div_num),
    .den    (div_den),
    .sts    (ists)
  );

  assign idx_inc  = idx + CNTW'(1);
  assign out_free = !rsp_valid || !rsp_stall;
  assign mem_we   = (state == B_IDLE) && !q_empty && !q_cmd.is_cast;

  assign ictl.start = (state == B_SQGO) || (state == B_DIVGO);
  assign ictl.mode  = (state == B_SQGO) ? MODE_SQRT : MODE_DIV;

  // Product terms of one shape. Circle: a, b, c, then b*b - a*c.
  // Segment: den, n1 and n2 as 2-D cross products.
  always_comb begin
    opx      = '0;
    opy      = '0;
    tsub     = 1'b0;
    tend     = 1'b0;
    to_check = 1'b0;
    to_disc  = 1'b0;
    if (kind_cur == KIND_CIRCLE) begin
      case (term)
        4'd0: begin opx = sop_t'(dx); opy = sop_t'(dx); end
        4'd1: begin opx = sop_t'(dy); opy = sop_t'(dy); tend = 1'b1; end
        4'd2: begin opx = sop_t'(ux); opy = sop_t'(dx); end
        4'd3: begin opx = sop_t'(uy); opy = sop_t'(dy); tend = 1'b1; end
        4'd4: begin opx = sop_t'(ux); opy = sop_t'(ux); end
        4'd5: begin opx = sop_t'(uy); opy = sop_t'(uy); end
        4'd6: begin
          opx = sop_t'(rad); opy = sop_t'(rad); tsub = 1'b1;
          tend = 1'b1; to_check = 1'b1;
        end
        4'd7: begin opx = rb; opy = rb; end
        4'd8: begin opx = ra; opy = rc; tsub = 1'b1; to_disc = 1'b1; end
        default: ;
      endcase
    end else begin
      case (term)
        4'd0: begin opx = sop_t'(dx); opy = sop_t'(v2y); end
        4'd1: begin opx = sop_t'(dy); opy = sop_t'(v2x); tsub = 1'b1; tend = 1'b1; end
        4'd2: begin opx = sop_t'(v2x); opy = sop_t'(uy); end
        4'd3: begin opx = sop_t'(v2y); opy = sop_t'(ux); tsub = 1'b1; tend = 1'b1; end
        4'd4: begin opx = sop_t'(dx); opy = sop_t'(uy); end
        4'd5: begin
          opx = sop_t'(dy); opy = sop_t'(ux); tsub = 1'b1;
          tend = 1'b1; to_check = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign la      = mcnt[1] ? magx[OPW-1:LIMB_W] : magx[LIMB_W-1:0];
  assign lb      = mcnt[0] ? magy[OPW-1:LIMB_W] : magy[LIMB_W-1:0];
  assign pp_wide = ACC_W'(pp);

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = pp_wide;
      2'd1:    pp_ext = pp_wide << LIMB_W;
      default: pp_ext = pp_wide << (2 * LIMB_W);
    endcase
  end

  assign acc_sum = tneg ? (acc - pp_ext) : (acc + pp_ext);

  // Segment values are brought to a positive denominator before the tests.
  assign sden    = ra[OPW-1] ? -ra : ra;
  assign sn1     = ra[OPW-1] ? -rb : rb;
  assign sn2     = ra[OPW-1] ? -rc : rc;
  assign seg_hit = (ra != '0) && !sn1[OPW-1] && (sn1 != '0) && !sn2[OPW-1] &&
                   (sn2 <= sden);
  assign circ_ok = (ra != '0) && !rc[OPW-1] && (rc != '0) && rb[OPW-1];
  assign nb      = -rb;
  assign cnum    = nb[DEN_W-1:0] - ists.root;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_cmd.is_cast) begin
            state_next = (q_slot == '0) ? B_OUT : B_READ;
          end
        end
      end
      B_READ:  state_next = B_PREP;
      B_PREP:  state_next = B_TLOAD;
      B_TLOAD: state_next = B_TMUL;
      B_TMUL: begin
        if (mcnt == 3'd4) begin
          if (to_check) begin
            state_next = B_CHECK;
          end else if (to_disc) begin
            state_next = B_DISC;
          end else begin
            state_next = B_TLOAD;
          end
        end
      end
      B_CHECK: begin
        if (kind_cur == KIND_CIRCLE) begin
          state_next = circ_ok ? B_TLOAD : B_NEXT;
        end else begin
          state_next = seg_hit ? B_DIVGO : B_NEXT;
        end
      end
      B_DISC:  state_next = acc[ACC_W-1] ? B_NEXT : B_SQGO;
      B_SQGO:  state_next = B_SQRT;
      B_SQRT: begin
        if (ists.done) begin
          state_next = B_DIVGO;
        end
      end
      B_DIVGO: state_next = B_DIV;
      B_DIV: begin
        if (ists.done) begin
          state_next = B_NEXT;
        end
      end
      B_NEXT:  state_next = (idx_inc == n_shapes) ? B_OUT : B_READ;
      B_OUT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == B_OUT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      scene_mem[q_slot[IDXW-1:0]] <= {q_cmd.kind, q_cmd.word_a, q_cmd.word_b};
    end
    rd_word <= scene_mem[idx[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty && q_cmd.is_cast) begin
          ox       <= q_cmd.word_a[31:0];
          oy       <= q_cmd.word_a[63:32];
          dx       <= q_cmd.word_b[31:0];
          dy       <= q_cmd.word_b[63:32];
          n_shapes <= q_slot;
          ovf_snap <= q_cmd.ovf;
          idx      <= '0;
          found    <= 1'b0;
          best     <= '0;
        end
      end
      B_PREP: begin
        kind_cur <= rd_word[128];
        ux       <= {ox[31], ox} - {rd_word[95], rd_word[95:64]};
        uy       <= {oy[31], oy} - {rd_word[127], rd_word[127:96]};
        v2x      <= {rd_word[31], rd_word[31:0]} - {rd_word[95], rd_word[95:64]};
        v2y      <= {rd_word[63], rd_word[63:32]} - {rd_word[127], rd_word[127:96]};
        rad      <= rd_word[30:0];
        term     <= '0;
        acc      <= '0;
      end
      B_TLOAD: begin
        magx <= opx[OPW-1] ? -opx : opx;
        magy <= opy[OPW-1] ? -opy : opy;
        tneg <= opx[OPW-1] ^ opy[OPW-1] ^ tsub;
        mcnt <= '0;
      end
      B_TMUL: begin
        // Four limb products issue on counts 0..3 and are summed in the next cycle.
        if (mcnt != 3'd4) begin
          pp    <= la * lb;
          pp_sh <= {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
        end
        // The accumulator restarts once a finished value has been taken out.
        if ((mcnt == 3'd4) && tend) begin
          acc <= '0;
        end else if (mcnt != 3'd0) begin
          acc <= acc_sum;
        end
        mcnt <= mcnt + 3'd1;
        if (mcnt == 3'd4) begin
          term <= term + 4'd1;
          if (tend) begin
            if (term < 4'd2) begin
              ra <= acc_sum[OPW-1:0];
            end else if (term < 4'd4) begin
              rb <= acc_sum[OPW-1:0];
            end else begin
              rc <= acc_sum[OPW-1:0];
            end
          end
        end
      end
      B_CHECK: begin
        div_num <= NUM_W'(sn1[DEN_W-1:0]) << FRAC_BITS;
        div_den <= sden[DEN_W-1:0];
      end
      B_DISC: begin
        sq_val <= acc[SQ_W-1:0];
      end
      B_SQRT: begin
        if (ists.done) begin
          div_num <= NUM_W'(cnum) << FRAC_BITS;
          div_den <= ra[DEN_W-1:0];
        end
      end
      B_DIV: begin
        if (ists.done && (!found || (ists.quot < best))) begin
          best  <= ists.quot;
          found <= 1'b1;
        end
      end
      B_NEXT: begin
        idx <= idx_inc;
      end
      B_OUT: begin
        if (out_free) begin
          rsp.hit            <= found;
          rsp.distance       <= found ? best : 32'd0;
          rsp.scene_overflow <= ovf_snap;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ray_nearest_hit_2d.sv =====
// Top level of the ray nearest-hit block: front end, command queue, back end.
//
//   channel  | valid     | stall     | payload
//   request  | req_valid | req_stall | req (rnh_pkg::req_t)
//   result   | rsp_valid | rsp_stall | rsp (rnh_pkg::rsp_t)
//
// A shape load is written into the scene memory as the back end pops it; a cast
// walks every stored shape, at a cost per shape set by the shared two-limb
// multiplier and the one-bit-per-cycle root and divide unit, higher for circles
// than for segments. Shapes that miss early skip the root and divide steps.
// Reset is synchronous and empties the scene; the memory itself is not cleared.
// The front end keeps taking requests while the two-entry queue has room, so a
// stalled result holds up the back end, and requests only once the queue fills.
module ray_nearest_hit_2d #(
  parameter int MAX_SHAPES = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rnh_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rnh_pkg::rsp_t rsp
);
  import rnh_pkg::*;

  localparam int CNTW = $clog2(MAX_SHAPES + 1);
  localparam int IDXW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int QW   = CNTW + $bits(cmd_t);

  logic            push;
  logic [CNTW-1:0] push_slot;
  cmd_t            push_cmd;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  logic [QW-1:0]   q_rdata;
  logic [CNTW-1:0] q_slot;
  cmd_t            q_cmd;

  rnh_front #(.MAX_SHAPES(MAX_SHAPES), .CNTW(CNTW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_slot (push_slot),
    .push_cmd  (push_cmd)
  );

  rnh_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_slot, push_cmd}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_slot = q_rdata[QW-1:QW-CNTW];
  assign q_cmd  = q_rdata[QW-CNTW-1:0];

  rnh_back #(
    .MAX_SHAPES (MAX_SHAPES),
    .FRAC_BITS  (FRAC_BITS),
    .CNTW       (CNTW),
    .IDXW       (IDXW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_slot    (q_slot),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== hw/rtl/rnh_checker.sv =====
// Port-level checker for the ray nearest-hit block, with its bind.
module rnh_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input rnh_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rnh_pkg::rsp_t rsp
);
  import rnh_pkg::*;

  logic [3:0] pending;
  logic       ovf_seen;
  logic       cast_take;
  logic       rsp_take;

  assign cast_take = req_valid && !req_stall && (req.opcode == OP_CAST_RAY);
  assign rsp_take  = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 4'd0;
      ovf_seen <= 1'b0;
    end else begin
      pending <= pending + {3'd0, cast_take} - {3'd0, rsp_take};
      if (rsp_take && rsp.scene_overflow) begin
        ovf_seen <= 1'b1;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.distance == 32'd0)
    else $error("miss with nonzero distance");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ovf_seen |-> rsp.scene_overflow)
    else $error("overflow flag dropped");

  a_rsp_has_cast: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 4'd0)
    else $error("result without a pending cast");

endmodule

bind ray_nearest_hit_2d rnh_checker u_rnh_checker (.*);
